@@ design/rled_pkg.sv @@
// ----------------------------------------------------------------------------
// rled_pkg: shared types and constants of the bitmap RLE4/RLE8 run decoder
// Holds the field widths, the input kinds, the escape and register codes,
// the record and palette request structs and the RGB565 packing function.
// ----------------------------------------------------------------------------
package rled_pkg;

  localparam int CFG_W  = 13;  // width and height registers
  localparam int BYTE_W = 8;
  localparam int RGB_W  = 24;
  localparam int POS_W  = 12;  // row and column fields of a record
  localparam int LEN_W  = 8;
  localparam int IN_DATA_W  = 40;  // stream_byte, palette_index, palette_rgb
  localparam int OUT_DATA_W = 80;  // row, start_column, run_length, colors
  localparam int CFG_IDX_W  = 2;

  // Input kinds carried in tuser
  localparam logic [1:0] MODE_PAL   = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  // Escape codes after a zero command byte
  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_EOF   = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK   = 2'd3;

  // One run record on its way to the output
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [LEN_W-1:0] len;
    logic             eoi;    // end of bitmap record
    logic             black;  // force both colors to zero
  } rled_rec_t;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] idx;
    logic [RGB_W-1:0]  rgb;
  } rled_wr_t;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] idx_even;
    logic [BYTE_W-1:0] idx_odd;
  } rled_rd_t;

  function automatic logic [RGB_W-1:0] rled_fmt(input logic [RGB_W-1:0] c,
                                               input logic pack);
    logic [RGB_W-1:0] res;
    if (pack) begin
      res = {8'd0, c[23:19], c[15:10], c[7:3]};
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

@@ design/rled_parser.sv @@
// ----------------------------------------------------------------------------
// rled_parser: stream parser and pen state
// Walks the RLE command bytes one per transfer, moves the pen and forms one
// run record plus palette read indexes for each byte that draws pixels.
// ----------------------------------------------------------------------------
module rled_parser #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [1:0]                     mode,
  input  logic [rled_pkg::BYTE_W-1:0]    sbyte,
  input  logic [rled_pkg::CFG_W-1:0]     cfg_width,
  input  logic [rled_pkg::CFG_W-1:0]     cfg_height,
  input  logic                           cfg_four,
  output logic                           emit,
  output rled_pkg::rled_rec_t            rec,
  output rled_pkg::rled_rd_t             rd
);
  import rled_pkg::*;

  typedef enum logic [2:0] {
    PH_CMD, PH_RUNVAL, PH_ESC, PH_DX, PH_DY, PH_ABS, PH_PAD
  } phase_t;

  localparam int CfgMax  = (1 << CFG_W) - 1;
  localparam int MaxClip = (MAX_DIM > CfgMax) ? CfgMax : MAX_DIM;
  localparam logic [CFG_W-1:0] MAX_C = CFG_W'(MaxClip);

  phase_t              phase_r, phase_nxt;
  logic [CFG_W-1:0]    col_r, col_nxt;
  logic [CFG_W-1:0]    row_r, row_nxt;
  logic [BYTE_W-1:0]   pend_r, pend_nxt;
  logic                pad_r, pad_nxt;
  logic                fin_r, fin_nxt;

  logic [CFG_W-1:0]    eff_w;
  logic [CFG_W-1:0]    eff_h;
  logic [CFG_W-1:0]    room;
  logic [CFG_W:0]      dx_sum;
  logic                col_ok;
  logic [BYTE_W-1:0]   n_req;
  logic [BYTE_W-1:0]   n_clip;
  logic [BYTE_W-1:0]   pend_dec;

  always_comb begin
    eff_w  = (cfg_width > MAX_C) ? MAX_C : cfg_width;
    eff_h  = (cfg_height > MAX_C) ? MAX_C : cfg_height;
    col_ok = col_r < eff_w;
    room   = eff_w - col_r;
    if (phase_r == PH_ABS && cfg_four && pend_r >= 8'd2) begin
      n_req = 8'd2;
    end else if (phase_r == PH_ABS) begin
      n_req = 8'd1;
    end else begin
      n_req = pend_r;
    end
    n_clip   = ({5'd0, n_req} > room) ? room[BYTE_W-1:0] : n_req;
    pend_dec = pend_r - n_req;
    dx_sum   = {1'b0, col_r} + {6'd0, sbyte};

    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    pad_nxt   = pad_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    rec.row   = row_r[POS_W-1:0];
    rec.col   = col_r[POS_W-1:0];
    rec.len   = n_clip;
    rec.eoi   = 1'b0;
    rec.black = 1'b0;

    rd.en       = 1'b0;
    rd.idx_even = cfg_four ? {4'd0, sbyte[7:4]} : sbyte;
    rd.idx_odd  = cfg_four ? {4'd0, sbyte[3:0]} : sbyte;

    if (mode == MODE_FRAME) begin
      row_nxt   = (eff_h == '0) ? '0 : eff_h - 1'b1;
      col_nxt   = '0;
      phase_nxt = PH_CMD;
      pend_nxt  = '0;
      pad_nxt   = 1'b0;
      fin_nxt   = 1'b0;
    end else if (mode == MODE_BYTE && !fin_r) begin
      case (phase_r)
        PH_CMD: begin
          if (sbyte != '0) begin
            pend_nxt  = sbyte;
            phase_nxt = PH_RUNVAL;
          end else begin
            phase_nxt = PH_ESC;
          end
        end
        PH_RUNVAL: begin
          phase_nxt = PH_CMD;
          if (col_ok) begin
            emit    = 1'b1;
            col_nxt = col_r + {5'd0, n_clip};
          end
        end
        PH_ESC: begin
          if (sbyte == ESC_EOF || (sbyte == ESC_EOL && row_r == '0)) begin
            emit      = 1'b1;
            rec.len   = '0;
            rec.eoi   = 1'b1;
            rec.black = 1'b1;
            fin_nxt   = 1'b1;
            phase_nxt = PH_CMD;
          end else if (sbyte == ESC_EOL) begin
            row_nxt   = row_r - 1'b1;
            col_nxt   = '0;
            phase_nxt = PH_CMD;
          end else if (sbyte == ESC_DELTA) begin
            phase_nxt = PH_DX;
          end else begin
            pend_nxt  = sbyte;
            pad_nxt   = 1'b0;
            phase_nxt = PH_ABS;
          end
        end
        PH_DX: begin
          col_nxt   = (dx_sum > {1'b0, eff_w}) ? eff_w : dx_sum[CFG_W-1:0];
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          if ({5'd0, sbyte} > row_r) begin
            emit      = 1'b1;
            rec.len   = '0;
            rec.eoi   = 1'b1;
            rec.black = 1'b1;
            fin_nxt   = 1'b1;
          end else begin
            row_nxt = row_r - {5'd0, sbyte};
          end
          phase_nxt = PH_CMD;
        end
        PH_ABS: begin
          pend_nxt = pend_dec;
          pad_nxt  = ~pad_r;
          if (col_ok) begin
            emit    = 1'b1;
            col_nxt = col_r + {5'd0, n_clip};
          end
          if (pend_dec == '0) begin
            phase_nxt = pad_r ? PH_CMD : PH_PAD;
          end
        end
        PH_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_CMD;
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
    end
    rd.en = accept && emit && !rec.black;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      pad_r   <= 1'b0;
      fin_r   <= 1'b1;
    end else if (accept) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      pad_r   <= pad_nxt;
      fin_r   <= fin_nxt;
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> phase_r == PH_CMD)
    else $error("finished decoder left in mid-command");

  a_abs_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ABS |-> pend_r != '0)
    else $error("absolute mode entered with no bytes pending");

endmodule

@@ design/rled_palette.sv @@
// ----------------------------------------------------------------------------
// rled_palette: color lookup table
// One write port and two registered read ports; per-entry valid bits make
// never-written entries read as black straight out of reset.
// ----------------------------------------------------------------------------
module rled_palette #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rled_pkg::rled_wr_t            wr,
  input  rled_pkg::rled_rd_t            rd,
  output logic [rled_pkg::RGB_W-1:0]    color_even,
  output logic [rled_pkg::RGB_W-1:0]    color_odd
);
  import rled_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [BYTE_W:0] NUM_E = (BYTE_W + 1)'(PALETTE_ENTRIES);

  logic [RGB_W-1:0]           mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r;
  logic [RGB_W-1:0]           even_r, odd_r;
  logic                       even_hit_r, odd_hit_r;
  logic                       wr_ok, even_ok, odd_ok;

  always_comb begin
    wr_ok   = {1'b0, wr.idx} < NUM_E;
    even_ok = {1'b0, rd.idx_even} < NUM_E;
    odd_ok  = {1'b0, rd.idx_odd} < NUM_E;
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_ok) begin
      mem[wr.idx[AW-1:0]] <= wr.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en && wr_ok) begin
      vld_r[wr.idx[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      even_r     <= mem[rd.idx_even[AW-1:0]];
      odd_r      <= mem[rd.idx_odd[AW-1:0]];
      even_hit_r <= even_ok && vld_r[rd.idx_even[AW-1:0]];
      odd_hit_r  <= odd_ok && vld_r[rd.idx_odd[AW-1:0]];
    end
  end

  assign color_even = even_hit_r ? even_r : '0;
  assign color_odd  = odd_hit_r ? odd_r : '0;

endmodule

@@ design/rled_out.sv @@
// ----------------------------------------------------------------------------
// rled_out: record stage and output register
// Holds a record beside its palette read data, applies the color format and
// moves it into the output register when that register is free.
// ----------------------------------------------------------------------------
module rled_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  rled_pkg::rled_rec_t                rec,
  input  logic [rled_pkg::RGB_W-1:0]         color_even,
  input  logic [rled_pkg::RGB_W-1:0]         color_odd,
  input  logic                               pack_565,
  output logic                               ready,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rled_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);
  import rled_pkg::*;

  rled_rec_t               s1_rec_r;
  logic                    s1_vld_r, s1_vld_nxt;
  logic                    s1_adv;
  logic                    out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0]   data_r, data_nxt;
  logic                    last_r;
  logic [RGB_W-1:0]        ce, co;

  always_comb begin
    s1_adv      = s1_vld_r && (!out_vld_r || out_tready);
    ready       = !s1_vld_r || s1_adv;
    s1_vld_nxt  = load ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
    ce          = s1_rec_r.black ? '0 : rled_fmt(color_even, pack_565);
    co          = s1_rec_r.black ? '0 : rled_fmt(color_odd, pack_565);
    data_nxt    = {co, ce, s1_rec_r.len, s1_rec_r.col, s1_rec_r.row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_rec_r <= rec;
    end
    if (s1_adv) begin
      data_r <= data_nxt;
      last_r <= s1_rec_r.eoi;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

@@ design/bmp_rle4_rle8_run_decoder.sv @@
// ----------------------------------------------------------------------------
// bmp_rle4_rle8_run_decoder: bitmap RLE8/RLE4 run decoder
// Turns palette writes, frame starts and RLE stream bytes into run records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transfer per item. in_tuser carries the kind:
//   palette write, stream byte or frame start. A frame start puts the pen at
//   column 0 of the bottom row; stream bytes are ignored until one arrives.
//   Result channel (out_*): one run record per drawing byte, and one end
//   record (run_length 0, black, out_tlast high) on end of bitmap or when the
//   row would pass below zero. Fully clipped pixels give no record.
//   Config channel (cfg_*): always ready; write only while the decoder is
//   idle. Index 0 width, 1 height, 2 RLE4 select, 3 RGB565 select.
// Timing:
//   The parser and the palette read register into the record stage, the
//   color format registers into the output stage. One item per cycle is
//   sustained while the receiver keeps out_tready high; the palette's two
//   read ports serve both RLE4 nibbles in the same cycle. When the receiver
//   stalls, the output register holds and the record stage still takes one
//   more item; in_tready drops only when both are full.
// Reset: control state clears, the palette reads as black everywhere, the
//   decoder waits for a frame start.
// ----------------------------------------------------------------------------
module bmp_rle4_rle8_run_decoder #(
  parameter int MAX_DIM         = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: stream_byte[7:0], palette_index[15:8], palette_rgb[39:16]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rled_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]                           in_tuser,
  // out_tdata: row[11:0], start_column[23:12], run_length[31:24],
  //            color_even[55:32], color_odd[79:56]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rled_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tlast: end_of_image
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rled_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rled_pkg::CFG_W-1:0]           cfg_data
);
  import rled_pkg::*;

  logic [CFG_W-1:0]  width_r, height_r;
  logic              four_r, pack_r;
  logic              in_xfer;
  logic              emit;
  logic              stage_ready;
  rled_rec_t         rec;
  rled_rd_t          rd;
  rled_wr_t          wr;
  logic [RGB_W-1:0]  color_even, color_odd;

  assign cfg_ready = 1'b1;
  assign in_tready = stage_ready;
  assign in_xfer   = in_tvalid && in_tready;

  // Configuration registers; every write is taken, as cfg_ready is always high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(1);
      height_r <= CFG_W'(1);
      four_r   <= 1'b0;
      pack_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_FOUR:   four_r   <= cfg_data[0];
        CFG_PACK:   pack_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Palette write straight from the input transfer
  always_comb begin
    wr.en  = in_xfer && (in_tuser == MODE_PAL);
    wr.idx = in_tdata[15:8];
    wr.rgb = in_tdata[39:16];
  end

  rled_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_xfer),
    .mode       (in_tuser),
    .sbyte      (in_tdata[7:0]),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_four   (four_r),
    .emit       (emit),
    .rec        (rec),
    .rd         (rd)
  );

  rled_palette #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .rd         (rd),
    .color_even (color_even),
    .color_odd  (color_odd)
  );

  // Advance a record into the stage only on a transfer that draws or ends
  rled_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer && emit),
    .rec        (rec),
    .color_even (color_even),
    .color_odd  (color_odd),
    .pack_565   (pack_r),
    .ready      (stage_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[31:24] == '0 && out_tdata[79:32] == '0)
    else $error("end record carries pixels or color");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[31:24] != '0)
    else $error("run record with zero length");

  a_rle8_colors: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !four_r |-> out_tdata[55:32] == out_tdata[79:56])
    else $error("RLE8 record with differing colors");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output side is free");

endmodule

@@ sim/bmp_rle4_rle8_run_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// bmp_rle4_rle8_run_decoder_tb: self-checking bench for the RLE4/RLE8 decoder
// Streams palette writes, frame starts and compressed bytes into the decoder,
// models the parser and palette alongside it, and checks every run record
// that comes out against the modeled one, field by field and in order.
// ----------------------------------------------------------------------------
module bmp_rle4_rle8_run_decoder_tb;
  import rled_pkg::*;

  localparam int DIM_LIMIT     = 4096;  // matches the decoder's MAX_DIM
  localparam int PAL_SIZE      = 256;
  localparam int ITEM_GOAL     = 1900;  // decoded items before random stops
  localparam int STALL_LIMIT   = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES = 8;     // covers the two-stage pipeline
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int REPORT_LINES  = 40;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused kind, must be dropped

  // Parser phases of the modeled decoder
  typedef enum logic [2:0] {
    ST_CMD, ST_RUNVAL, ST_ESC, ST_DX, ST_DY, ST_LIT, ST_PAD
  } parse_st_t;

  // One run record, fields in the order they are compared
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [LEN_W-1:0] len;
    logic [RGB_W-1:0] even;
    logic [RGB_W-1:0] odd;
    logic             eoi;
  } run_rec_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = MODE_PAL;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_WIDTH;
  logic [CFG_W-1:0]      cfg_data   = '0;

  // Modeled decoder state and register copies
  logic [RGB_W-1:0] pal [PAL_SIZE];
  parse_st_t        parse_st;
  int               pen_col;
  int               pen_row;
  int               lit_left;
  bit               lit_odd;
  bit               pen_done;
  int               reg_width;
  int               reg_height;
  bit               reg_four;
  bit               reg_pack;

  run_rec_t runs_due[$];  // records the decoder still owes, oldest first

  int items_sent    = 0;
  int items_decoded = 0;
  int records_seen  = 0;
  int ends_seen     = 0;
  int configs_done  = 0;
  int err_count     = 0;
  int idle_cycles   = 0;
  int in_gap_max    = 0;
  int out_gap_max   = 0;
  int hold_cycles   = 0;

  bmp_rle4_rle8_run_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  function automatic int used_width();
    return (reg_width > DIM_LIMIT) ? DIM_LIMIT : reg_width;
  endfunction

  // Palette color in the selected output format
  function automatic logic [RGB_W-1:0] shade(input logic [7:0] idx);
    logic [RGB_W-1:0] c;
    logic [RGB_W-1:0] res;
    c = pal[idx];
    if (reg_pack) begin
      // red 7:3 to 15:11, green 7:2 to 10:5, blue 7:3 to 4:0
      res = ((c >> 8) & 24'h00F800) | ((c >> 5) & 24'h0007E0) | ((c & 24'hFF) >> 3);
    end else begin
      res = c;
    end
    return res;
  endfunction

  task automatic push_run(input int len, input logic [RGB_W-1:0] ce,
                          input logic [RGB_W-1:0] co, input bit eoi);
    run_rec_t r;
    r.row  = POS_W'(pen_row);
    r.col  = POS_W'(pen_col);
    r.len  = LEN_W'(len);
    r.even = ce;
    r.odd  = co;
    r.eoi  = eoi;
    runs_due.push_back(r);
  endtask

  // End of bitmap or row underflow: black end record, decoder stops
  task automatic close_frame();
    pen_done = 1'b1;
    parse_st = ST_CMD;
    push_run(0, '0, '0, 1'b1);
  endtask

  // Pixels of one byte at the pen, clipped to the row
  task automatic paint(input int count, input logic [7:0] val);
    int room;
    int n;
    logic [RGB_W-1:0] ce;
    logic [RGB_W-1:0] co;
    n = count;
    room = used_width() - pen_col;
    if (room <= 0) return;
    if (n > room) n = room;
    if (n == 0) return;
    if (reg_four) begin
      ce = shade({4'd0, val[7:4]});
      co = shade({4'd0, val[3:0]});
    end else begin
      ce = shade(val);
      co = ce;
    end
    push_run(n, ce, co, 1'b0);
    pen_col += n;
  endtask

  // Advance the model by one accepted item
  task automatic decode_item(input logic [1:0] kind, input logic [7:0] sb,
                             input logic [7:0] pidx, input logic [RGB_W-1:0] prgb);
    int h;
    int n;
    case (kind)
      MODE_PAL: begin
        pal[pidx] = prgb;
        items_decoded++;
      end
      MODE_FRAME: begin
        h = (reg_height > DIM_LIMIT) ? DIM_LIMIT : reg_height;
        pen_row  = (h == 0) ? 0 : h - 1;
        pen_col  = 0;
        parse_st = ST_CMD;
        lit_left = 0;
        lit_odd  = 1'b0;
        pen_done = 1'b0;
        items_decoded++;
      end
      MODE_BYTE: begin
        if (!pen_done) begin
          items_decoded++;
          case (parse_st)
            ST_CMD: begin
              if (sb != 8'd0) begin
                lit_left = sb;
                parse_st = ST_RUNVAL;
              end else begin
                parse_st = ST_ESC;
              end
            end
            ST_RUNVAL: begin
              parse_st = ST_CMD;
              paint(lit_left, sb);
            end
            ST_ESC: begin
              if (sb == ESC_EOF) begin
                close_frame();
              end else if (sb == ESC_EOL) begin
                if (pen_row == 0) begin
                  close_frame();
                end else begin
                  pen_row--;
                  pen_col  = 0;
                  parse_st = ST_CMD;
                end
              end else if (sb == ESC_DELTA) begin
                parse_st = ST_DX;
              end else begin
                lit_left = sb;
                lit_odd  = 1'b0;
                parse_st = ST_LIT;
              end
            end
            ST_DX: begin
              pen_col += sb;
              if (pen_col > used_width()) pen_col = used_width();
              parse_st = ST_DY;
            end
            ST_DY: begin
              if (sb > pen_row) begin
                close_frame();
              end else begin
                pen_row -= sb;
                parse_st = ST_CMD;
              end
            end
            ST_LIT: begin
              // RLE4 takes two nibbles per byte while two remain
              n = (reg_four && lit_left >= 2) ? 2 : 1;
              if (n > lit_left) n = lit_left;
              lit_left -= n;
              lit_odd  ^= 1'b1;
              paint(n, sb);
              if (lit_left == 0) parse_st = lit_odd ? ST_PAD : ST_CMD;
            end
            ST_PAD: begin
              lit_odd  = 1'b0;
              parse_st = ST_CMD;
            end
            default: parse_st = ST_CMD;
          endcase
        end
      end
      default: ;  // spare kind: dropped
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then idle for a drawn gap.
  // With no gap the valid stays high so the next item follows back to back.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] sb,
                           input logic [7:0] pidx, input logic [RGB_W-1:0] prgb);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {prgb, pidx, sb};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    decode_item(kind, sb, pidx, prgb);
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Unused fields carry random filler so every bit toggles
  task automatic send_byte(input logic [7:0] b);
    send_item(MODE_BYTE, b, $urandom(), $urandom());
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [RGB_W-1:0] rgb);
    send_item(MODE_PAL, $urandom(), idx, rgb);
  endtask

  task automatic send_frame();
    send_item(MODE_FRAME, $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_spare();
    send_item(MODE_SPARE, $urandom(), $urandom(), $urandom());
  endtask

  // Drop valid, wait for every owed record, then let the pipeline drain
  // items that produce nothing.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  reg_width  = val & 32'h1FFF;
      CFG_HEIGHT: reg_height = val & 32'h1FFF;
      CFG_FOUR:   reg_four   = val[0];
      CFG_PACK:   reg_pack   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int w, input int h, input bit four, input bit pack);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_FOUR, four);
    write_reg(CFG_PACK, pack);
    cfg_valid <= 1'b0;
    configs_done++;
  endtask

  function automatic int gap_limit();
    int lim;
    case ($urandom_range(0, 2))
      0:       lim = 0;
      1:       lim = 3;
      default: lim = 18;
    endcase
    return lim;
  endfunction

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Receiver: a drawn stall before each record, or a long hold on request
  initial begin
    int wait_n;
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        wait_n = $urandom_range(0, out_gap_max);
        if (wait_n > 0) begin
          out_tready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid && hold_cycles == 0);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [RGB_W-1:0] got,
                                 input logic [RGB_W-1:0] want);
    err_count++;
    if (err_count <= REPORT_LINES)
      $display("mismatch at record %0d: %s got %0h, want %0h",
               records_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [RGB_W-1:0] got,
                             input logic [RGB_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare each transferred record with the oldest one owed
  always @(posedge clk) begin
    run_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (runs_due.size() == 0) begin
        report_mismatch("record with none owed, row", out_tdata[11:0], '0);
      end else begin
        want = runs_due.pop_front();
        check_field("row",          out_tdata[11:0],  want.row);
        check_field("start_column", out_tdata[23:12], want.col);
        check_field("run_length",   out_tdata[31:24], want.len);
        check_field("color_even",   out_tdata[55:32], want.even);
        check_field("color_odd",    out_tdata[79:56], want.odd);
        check_field("end_of_image", out_tlast,        want.eoi);
      end
      records_seen++;
      if (out_tlast === 1'b1) ends_seen++;
    end
  end

  // Watchdog: end the run when no channel moves for too long
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: %0d cycles without a transfer, %0d records owed",
             STALL_LIMIT, runs_due.size());
    $display("** bmp_rle4_rle8_run_decoder: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: width 1, height 1, RLE8, RGB565
  task automatic test_defaults();
    in_gap_max  = 18;
    out_gap_max = 0;
    send_byte(8'h05);                    // no frame yet: dropped
    send_spare();
    send_frame();
    send_pal(8'hFF, 24'hFFFFFF);
    send_byte(8'hFF); send_byte(8'hFF);  // 255 pixels clipped to one
    send_byte(8'h01); send_byte(8'h00);  // pen at the edge: fully clipped
    send_byte(8'h00); send_byte(ESC_DELTA);
    send_byte(8'h00); send_byte(8'h01);  // step below row 0: end record
    send_frame();
    send_byte(8'h00); send_byte(ESC_EOL);  // end of line on row 0
  endtask

  // Largest image, RLE4 nibbles, RGB888 colors
  task automatic test_rle4_extremes();
    apply_config(DIM_LIMIT, DIM_LIMIT, 1'b1, 1'b0);
    in_gap_max  = 0;
    out_gap_max = 18;
    send_frame();
    send_pal(8'h0F, 24'hFFFFFF);
    send_byte(8'hFF); send_byte(8'h0F);    // 255 pixels, black and white
    send_byte(8'h00); send_byte(8'h05);    // five literal pixels in three bytes
    send_byte(8'hF0); send_byte(8'h0F); send_byte(8'hAB);
    send_byte(8'h5A);                      // pad byte
    send_byte(8'h00); send_byte(ESC_DELTA);
    send_byte(8'hFF); send_byte(8'h05);
    send_byte(8'h00); send_byte(ESC_EOF);
  endtask

  // Hold the receiver off while the sender keeps offering runs, so the
  // decoder fills up and must stall its input.
  task automatic test_output_stall();
    int k;
    apply_config(DIM_LIMIT, 64, 1'b0, 1'b1);
    in_gap_max  = 0;
    out_gap_max = 0;
    send_frame();
    hold_cycles = HOLD_CYCLES;
    for (k = 0; k < 24; k++) begin
      send_byte($urandom_range(1, 255));
      send_byte($urandom());
    end
    send_byte(8'h00); send_byte(ESC_EOF);
  endtask

  // Mostly well-formed streams with random content, some noise mixed in
  task automatic test_random_streams();
    int w;
    int h;
    int frames;
    int cmds;
    int f;
    int k;
    int pick;
    int cnt;
    int nbytes;
    while (items_decoded < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0:       w = 1;
        1:       w = DIM_LIMIT;
        2, 3:    w = $urandom_range(1, 32);
        4:       w = $urandom_range(1, 300);
        default: w = $urandom_range(1, DIM_LIMIT);
      endcase
      case ($urandom_range(0, 4))
        0:       h = 1;
        1:       h = DIM_LIMIT;
        default: h = $urandom_range(1, 12);
      endcase
      apply_config(w, h, $urandom_range(0, 1), $urandom_range(0, 1));
      in_gap_max  = gap_limit();
      out_gap_max = gap_limit();
      // RLE4 can only reach the low sixteen entries
      repeat ($urandom_range(4, 12))
        send_pal((reg_four && $urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 255),
                 $urandom());
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        send_frame();
        cmds = $urandom_range(4, 40);
        for (k = 0; k < cmds && !pen_done; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            // encoded run, mostly short
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                              : $urandom_range(1, 16);
            send_byte(cnt);
            send_byte($urandom());
          end else if (pick < 60) begin
            // literal block, padded to an even byte count
            cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255)
                                               : $urandom_range(3, 14);
            nbytes = reg_four ? (cnt + 1) / 2 : cnt;
            send_byte(8'h00);
            send_byte(cnt);
            repeat (nbytes) send_byte($urandom());
            if (nbytes % 2 != 0) send_byte($urandom());
          end else if (pick < 72) begin
            send_byte(8'h00);
            send_byte(ESC_EOL);
          end else if (pick < 82) begin
            send_byte(8'h00);
            send_byte(ESC_DELTA);
            send_byte($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255));
            send_byte(($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                 : $urandom_range(0, 255));
          end else if (pick < 88) begin
            send_pal($urandom(), $urandom());
          end else if (pick < 94) begin
            send_byte($urandom());  // stray byte shifts the parse
          end else if (pick < 97) begin
            send_spare();
          end else begin
            // abandon an escape with a new frame
            send_byte(8'h00);
            send_frame();
          end
        end
        if (!pen_done && $urandom_range(0, 3) != 0) begin
          send_byte(8'h00);
          send_byte(ESC_EOF);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    int i;
    for (i = 0; i < PAL_SIZE; i++) pal[i] = '0;
    parse_st   = ST_CMD;
    pen_col    = 0;
    pen_row    = 0;
    lit_left   = 0;
    lit_odd    = 1'b0;
    pen_done   = 1'b1;
    reg_width  = 1;
    reg_height = 1;
    reg_four   = 1'b0;
    reg_pack   = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_rle4_extremes();
    test_output_stall();
    test_random_streams();

    // drain the last records, then give stray ones time to show up
    wait_idle();
    repeat (12) @(posedge clk);

    $display("covered %0d items (%0d decoded) over %0d register settings",
             items_sent, items_decoded, configs_done);
    $display("checked %0d run records, %0d of them end records, %0d mismatches",
             records_seen, ends_seen, err_count);
    if (err_count == 0) begin
      $display("** bmp_rle4_rle8_run_decoder: PASSED **");
    end else begin
      $display("** bmp_rle4_rle8_run_decoder: FAILED **");
    end
    $finish;
  end

endmodule
